// File: sv/imu_ma_pkg.sv
// ---------------------------------------------------------------------------
// imu_ma_pkg
// Shared types, constants and constant-divide helpers for the six-axis
// moving-average filter with gyro bias calibration.
// ---------------------------------------------------------------------------
package imu_ma_pkg;

    localparam int AXES        = 6;
    localparam int GYRO_AXES   = 3;
    localparam int GYRO_BASE   = 3;
    localparam int SAMPLE_W    = 16;
    localparam int TDATA_W     = AXES * SAMPLE_W;

    localparam int WINDOW_LEN  = 10;
    localparam int CAL_SKIP    = 50;
    localparam int CAL_SAMPLES = 100;
    localparam int CAL_TOTAL   = CAL_SKIP + CAL_SAMPLES;
    localparam int CNT_W       = $clog2(CAL_TOTAL + 1);

    // running window sum, wide enough for the magnitude of the most negative sum
    localparam int SUM_W       = SAMPLE_W + $clog2(WINDOW_LEN);
    localparam int WIN_SH      = SUM_W + $clog2(WINDOW_LEN);
    localparam int WIN_MUL_W   = SUM_W + 1;
    localparam int WIN_PROD_W  = SUM_W + WIN_MUL_W;
    localparam logic [63:0] WIN_MULT64 =
        ((64'd1 << WIN_SH) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
    localparam logic [WIN_MUL_W-1:0] WIN_MULT = WIN_MULT64[WIN_MUL_W-1:0];

    // calibration accumulator
    localparam int ACC_W       = SAMPLE_W + 1 + $clog2(CAL_SAMPLES);
    localparam int CAL_SH      = ACC_W + $clog2(CAL_SAMPLES);
    localparam int CAL_MUL_W   = ACC_W + 1;
    localparam int CAL_PROD_W  = ACC_W + CAL_MUL_W;
    localparam logic [63:0] CAL_MULT64 =
        ((64'd1 << CAL_SH) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
    localparam logic [CAL_MUL_W-1:0] CAL_MULT = CAL_MULT64[CAL_MUL_W-1:0];

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [SUM_W-1:0]    t_sum;
    typedef logic signed [ACC_W-1:0]    t_acc;

    typedef enum logic [1:0] {
        ACT_FILTER     = 2'd0,
        ACT_CAL_BEGIN  = 2'd1,
        ACT_CAL_SAMPLE = 2'd2
    } t_action;

    typedef struct packed {
        logic clear_windows;  // calibration just finished
    } t_cal_status;

    // window sum / WINDOW_LEN, truncated toward zero
    function automatic t_sample div_window(input t_sum s);
        logic [SUM_W-1:0]      mag;
        logic [WIN_PROD_W-1:0] prod;
        logic [SUM_W-1:0]      q;
        mag  = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
        prod = WIN_PROD_W'(mag) * WIN_PROD_W'(WIN_MULT);
        q    = SUM_W'(prod >> WIN_SH);
        if (s[SUM_W-1]) begin
            q = -q;
        end
        return t_sample'(q[SAMPLE_W-1:0]);
    endfunction

    // accumulator / CAL_SAMPLES, truncated toward zero
    function automatic t_sample div_cal(input t_acc s);
        logic [ACC_W-1:0]      mag;
        logic [CAL_PROD_W-1:0] prod;
        logic [ACC_W-1:0]      q;
        mag  = s[ACC_W-1] ? ACC_W'(-s) : ACC_W'(s);
        prod = CAL_PROD_W'(mag) * CAL_PROD_W'(CAL_MULT);
        q    = ACC_W'(prod >> CAL_SH);
        if (s[ACC_W-1]) begin
            q = -q;
        end
        return t_sample'(q[SAMPLE_W-1:0]);
    endfunction

endpackage

// File: sv/imu_ma_window.sv
// ---------------------------------------------------------------------------
// imu_ma_window
// Per-axis sample windows (shift lines) with running sums.
// ---------------------------------------------------------------------------
module imu_ma_window
    import imu_ma_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  logic    i_clear,
    input  t_sample i_sample [AXES],
    output t_sum    o_sum    [AXES]
);

    t_sample r_win [AXES][WINDOW_LEN];
    t_sum    r_sum [AXES];
    t_sum    n_sum [AXES];

    // drop the oldest tap, add the newest sample
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            n_sum[a] = r_sum[a] - SUM_W'(r_win[a][0]) + SUM_W'(i_sample[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            for (int a = 0; a < AXES; a++) begin
                r_sum[a] <= '0;
                for (int i = 0; i < WINDOW_LEN; i++) begin
                    r_win[a][i] <= '0;
                end
            end
        end else if (i_push) begin
            for (int a = 0; a < AXES; a++) begin
                for (int i = 0; i < WINDOW_LEN - 1; i++) begin
                    r_win[a][i] <= r_win[a][i+1];
                end
                r_win[a][WINDOW_LEN-1] <= i_sample[a];
                r_sum[a]               <= n_sum[a];
            end
        end
    end

    assign o_sum = r_sum;

endmodule

// File: sv/imu_ma_cal.sv
// ---------------------------------------------------------------------------
// imu_ma_cal
// Gyro bias calibration: sample counter, accumulators and bias registers.
// ---------------------------------------------------------------------------
module imu_ma_cal
    import imu_ma_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  t_action     i_action,
    input  t_sample     i_gyro [GYRO_AXES],
    output t_sample     o_bias [GYRO_AXES],
    output logic        o_bias_valid,
    output t_cal_status o_status
);

    logic [CNT_W-1:0] r_cnt;
    t_acc             r_acc  [GYRO_AXES];
    t_sample          r_bias [GYRO_AXES];
    logic             r_bias_valid;
    logic             r_fin;

    logic w_begin;
    logic w_sample;
    logic w_collect;
    logic w_last;

    assign w_begin   = i_accept && (i_action == ACT_CAL_BEGIN);
    assign w_sample  = i_accept && (i_action == ACT_CAL_SAMPLE) &&
                       (r_cnt < CNT_W'(CAL_TOTAL));
    assign w_collect = w_sample && (r_cnt >= CNT_W'(CAL_SKIP));
    assign w_last    = w_sample && (r_cnt == CNT_W'(CAL_TOTAL - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt        <= '0;
            r_fin        <= 1'b0;
            r_bias_valid <= 1'b0;
            for (int k = 0; k < GYRO_AXES; k++) begin
                r_acc[k]  <= '0;
                r_bias[k] <= '0;
            end
        end else begin
            r_fin <= w_last;
            if (w_begin) begin
                r_cnt        <= '0;
                r_bias_valid <= 1'b0;
                for (int k = 0; k < GYRO_AXES; k++) begin
                    r_acc[k]  <= '0;
                    r_bias[k] <= '0;
                end
            end else begin
                if (w_sample) begin
                    r_cnt <= r_cnt + 1'b1;
                end
                if (w_collect) begin
                    for (int k = 0; k < GYRO_AXES; k++) begin
                        r_acc[k] <= r_acc[k] + ACC_W'(i_gyro[k]);
                    end
                end
                // the cycle after the last sample: accumulators are final
                if (r_fin) begin
                    r_bias_valid <= 1'b1;
                    for (int k = 0; k < GYRO_AXES; k++) begin
                        r_bias[k] <= div_cal(r_acc[k]);
                    end
                end
            end
        end
    end

    assign o_bias                 = r_bias;
    assign o_bias_valid           = r_bias_valid;
    assign o_status.clear_windows = w_last;

endmodule

// File: sv/imu_ma_out.sv
// ---------------------------------------------------------------------------
// imu_ma_out
// Divide window sums, remove gyro bias, hold the result transaction.
// ---------------------------------------------------------------------------
module imu_ma_out
    import imu_ma_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  t_sum               i_sum  [AXES],
    input  t_sample            i_bias [GYRO_AXES],
    input  logic               i_bias_valid,
    input  logic               i_ready,
    output logic               o_valid,
    output logic [TDATA_W-1:0] o_data,
    output logic               o_user
);

    logic               r_valid;
    logic [TDATA_W-1:0] r_data;
    logic               r_user;
    logic [TDATA_W-1:0] n_data;

    always_comb begin
        t_sample avg;
        n_data = '0;
        for (int a = 0; a < AXES; a++) begin
            avg = div_window(i_sum[a]);
            if (a >= GYRO_BASE) begin
                avg = avg - i_bias[a-GYRO_BASE];
            end
            n_data[a*SAMPLE_W +: SAMPLE_W] = avg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= n_data;
            r_user <= i_bias_valid;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_user  = r_user;

endmodule

// File: sv/imu_six_axis_moving_average.sv
// ---------------------------------------------------------------------------
// imu_six_axis_moving_average: window sums and the result transaction are registered.
// Throughput 1 transaction/cycle; input stalls only on result back-pressure.
// Synchronous active-low reset clears windows, biases, counter, pipeline.
// ---------------------------------------------------------------------------
module imu_six_axis_moving_average
    import imu_ma_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input stream
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z,
    // [63:48] gyro_x, [79:64] gyro_y, [95:80] gyro_z
    input  logic [TDATA_W-1:0] i_s_axis_tdata,
    // [1:0] action
    input  logic [1:0]         i_s_axis_tuser,
    // result stream
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    // [15:0] accel_x_avg, [31:16] accel_y_avg, [47:32] accel_z_avg,
    // [63:48] gyro_x_avg, [79:64] gyro_y_avg, [95:80] gyro_z_avg
    output logic [TDATA_W-1:0] o_m_axis_tdata,
    // [0] bias_valid
    output logic               o_m_axis_tuser
);

    // Pipeline:
    //   accept edge  - window shift and running-sum update (sums registered)
    //   stage 1      - r_s1_valid marks that the registered sums hold a
    //                  result still to be divided; the sums, biases and
    //                  bias_valid are live state but only change on an
    //                  accept, when stage 1 is empty or moving on in the
    //                  same edge, or at the edge after the last calibration
    //                  transaction, when stage 1 is empty
    //   output stage - divide by the window length, subtract gyro bias,
    //                  registered result transaction
    //
    // Calibration completion clears the windows on the accepting edge and
    // computes the biases from the final accumulators at the following edge. A
    // filter transaction accepted at that later edge is not divided before
    // the next edge, so it already sees the new biases and input never waits.

    t_sample     w_sample [AXES];
    t_sample     w_gyro   [GYRO_AXES];
    t_action     w_action;
    t_sum        w_sum    [AXES];
    t_sample     w_bias   [GYRO_AXES];
    logic        w_bias_valid;
    t_cal_status w_cal_status;

    logic w_accept;
    logic w_push;
    logic w_out_free;
    logic w_s1_free;
    logic w_load;

    logic r_s1_valid;

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            w_sample[a] = i_s_axis_tdata[a*SAMPLE_W +: SAMPLE_W];
        end
        for (int k = 0; k < GYRO_AXES; k++) begin
            w_gyro[k] = w_sample[GYRO_BASE+k];
        end
    end

    // action code 3 has no member: it is accepted and does nothing
    assign w_action = t_action'(i_s_axis_tuser);

    // handshake and stage advance
    assign w_out_free      = !o_m_axis_tvalid || i_m_axis_tready;
    assign w_s1_free       = !r_s1_valid || w_out_free;
    assign o_s_axis_tready = w_s1_free;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_push          = w_accept && (w_action == ACT_FILTER);
    assign w_load          = r_s1_valid && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_push) begin
            r_s1_valid <= 1'b1;
        end else if (w_out_free) begin
            r_s1_valid <= 1'b0;
        end
    end

    imu_ma_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_clear  (w_cal_status.clear_windows),
        .i_sample (w_sample),
        .o_sum    (w_sum)
    );

    imu_ma_cal u_cal (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_action     (w_action),
        .i_gyro       (w_gyro),
        .o_bias       (w_bias),
        .o_bias_valid (w_bias_valid),
        .o_status     (w_cal_status)
    );

    imu_ma_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_load),
        .i_sum        (w_sum),
        .i_bias       (w_bias),
        .i_bias_valid (w_bias_valid),
        .i_ready      (i_m_axis_tready),
        .o_valid      (o_m_axis_tvalid),
        .o_data       (o_m_axis_tdata),
        .o_user       (o_m_axis_tuser)
    );

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: six-axis moving-average filter with gyro bias calibration
// Drives filter, calibration and reserved-action transactions into the
// stream input, predicts every filter result in step with the block, and
// checks each output transaction field by field in arrival order.
// ---------------------------------------------------------------------------
module tb_top;
    import imu_ma_pkg::*;

    // action code 3 has no enum member; the block must ignore it
    localparam logic [1:0] ACT_RESERVED = 2'd3;

    localparam int      RAND_ITEMS   = 1950;
    localparam int      IDLE_LIMIT   = 2000;  // cycles without any handshake
    localparam int      DRAIN_CYCLES = 8;     // pipeline is 2 deep, plus margin
    localparam int      DIR_ROWS     = 14;
    localparam t_sample S_MAX        = 16'sh7FFF;
    localparam t_sample S_MIN        = 16'sh8000;

    // one filter result: six averages in tdata order, bias_valid on top
    typedef struct packed {
        logic               bias_valid;
        logic [TDATA_W-1:0] avgs;
    } avg_result_t;

    // one row of the directed table; row_fixed selects the typed-in result
    typedef struct packed {
        logic [1:0]         act;
        logic [TDATA_W-1:0] data;
        logic               row_fixed;
        avg_result_t        want;
    } stim_row_t;

    // DUT ports, all inputs known from time zero
    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               i_s_axis_tvalid = 1'b0;
    logic               o_s_axis_tready;
    // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z,
    // [63:48] gyro_x, [79:64] gyro_y, [95:80] gyro_z
    logic [TDATA_W-1:0] i_s_axis_tdata  = '0;
    // [1:0] action
    logic [1:0]         i_s_axis_tuser  = '0;
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready = 1'b0;
    // [15:0] accel_x_avg, [31:16] accel_y_avg, [47:32] accel_z_avg,
    // [63:48] gyro_x_avg, [79:64] gyro_y_avg, [95:80] gyro_z_avg
    logic [TDATA_W-1:0] o_m_axis_tdata;
    // [0] bias_valid
    logic               o_m_axis_tuser;

    // predictor state, zero at time zero like the block after reset
    int hist [AXES][WINDOW_LEN];
    int win_sum [AXES];
    int gyro_off [GYRO_AXES];
    int cal_acc [GYRO_AXES];
    int cal_cnt;
    bit bias_ok;

    avg_result_t pending_avgs [$];
    int          burst_left  = 0;
    int          items_done  = 0;
    int          err_count   = 0;
    int          idle_cycles = 0;
    logic [15:0] rx_cnt      = '0;
    logic [1:0]  rx_mode     = '0;

    imu_six_axis_moving_average u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // -----------------------------------------------------------------------
    // Predictor: advances the window, bias and calibration state by one
    // accepted transaction. Returns 1 when the transaction yields a result.
    // -----------------------------------------------------------------------
    function automatic bit imu_filter_step(input logic [1:0] act,
                                           input logic [TDATA_W-1:0] data,
                                           output avg_result_t res);
        int s [AXES];
        int q;
        res = '0;
        for (int a = 0; a < AXES; a++) begin
            s[a] = int'(t_sample'(data[a*SAMPLE_W +: SAMPLE_W]));
        end
        case (act)
            ACT_FILTER: begin
                for (int a = 0; a < AXES; a++) begin
                    win_sum[a] -= hist[a][0];
                    for (int i = 1; i < WINDOW_LEN; i++) begin
                        hist[a][i-1] = hist[a][i];
                    end
                    hist[a][WINDOW_LEN-1] = s[a];
                    win_sum[a] += s[a];
                    // SV int division truncates toward zero, as the block must
                    q = win_sum[a] / WINDOW_LEN;
                    if (a >= GYRO_BASE) begin
                        q -= gyro_off[a-GYRO_BASE];
                    end
                    res.avgs[a*SAMPLE_W +: SAMPLE_W] = q[SAMPLE_W-1:0];
                end
                res.bias_valid = bias_ok;
                return 1'b1;
            end
            ACT_CAL_BEGIN: begin
                for (int k = 0; k < GYRO_AXES; k++) begin
                    gyro_off[k] = 0;
                    cal_acc[k]  = 0;
                end
                cal_cnt = 0;
                bias_ok = 1'b0;
            end
            ACT_CAL_SAMPLE: begin
                // once the count is full, samples are dropped until a begin
                if (cal_cnt < CAL_TOTAL) begin
                    if (cal_cnt >= CAL_SKIP) begin
                        for (int k = 0; k < GYRO_AXES; k++) begin
                            cal_acc[k] += s[GYRO_BASE+k];
                        end
                    end
                    cal_cnt++;
                    if (cal_cnt == CAL_TOTAL) begin
                        for (int k = 0; k < GYRO_AXES; k++) begin
                            gyro_off[k] = cal_acc[k] / CAL_SAMPLES;
                        end
                        for (int a = 0; a < AXES; a++) begin
                            for (int i = 0; i < WINDOW_LEN; i++) begin
                                hist[a][i] = 0;
                            end
                            win_sum[a] = 0;
                        end
                        bias_ok = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic logic [TDATA_W-1:0] pack6(input t_sample ax, input t_sample ay,
                                                  input t_sample az, input t_sample gx,
                                                  input t_sample gy, input t_sample gz);
        return {gz, gy, gx, az, ay, ax};
    endfunction

    function automatic logic [TDATA_W-1:0] all6(input t_sample v);
        return pack6(v, v, v, v, v, v);
    endfunction

    // biased toward the rails and toward small values around zero
    function automatic t_sample rand_sample();
        case ($urandom_range(0, 7))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return t_sample'(int'($urandom_range(0, 32)) - 16);
            default: return t_sample'($urandom);
        endcase
    endfunction

    function automatic logic [TDATA_W-1:0] rand_frame();
        return pack6(rand_sample(), rand_sample(), rand_sample(),
                     rand_sample(), rand_sample(), rand_sample());
    endfunction

    // gyro content of a calibration run: free, pinned high, pinned low, or
    // a steady offset with noise so the computed bias lands away from zero
    function automatic t_sample gyro_pick(input int mode, input t_sample base);
        case (mode)
            0:       return rand_sample();
            1:       return S_MAX;
            2:       return S_MIN;
            default: return t_sample'(int'(base) + int'($urandom_range(0, 128)) - 64);
        endcase
    endfunction

    // -----------------------------------------------------------------------
    // Sender: bursts of random length separated by random gaps. The
    // transaction is predicted at the edge where it is accepted.
    // -----------------------------------------------------------------------
    task automatic send_item(input logic [1:0] act, input logic [TDATA_W-1:0] data,
                             input bit row_fixed, input avg_result_t want);
        avg_result_t predicted;
        int          gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 24);
            if (gap != 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= data;
        i_s_axis_tuser  <= act;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        // ignored transactions (reserved code, samples past a finished
        // calibration) do not count toward the random budget
        if (act == ACT_FILTER || act == ACT_CAL_BEGIN ||
            (act == ACT_CAL_SAMPLE && cal_cnt < CAL_TOTAL)) begin
            items_done++;
        end
        if (imu_filter_step(act, data, predicted)) begin
            pending_avgs.push_back(row_fixed ? want : predicted);
        end
    endtask

    // -----------------------------------------------------------------------
    // Receiver: stall pattern is picked anew when the low byte of rx_cnt is zero,
    // among always ready, coin flip, one cycle in four, and 12-of-16 duty.
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        rx_cnt <= rx_cnt + 16'd1;
        if (rx_cnt[7:0] == 8'd0) begin
            rx_mode <= 2'($urandom_range(0, 3));
        end
        case (rx_mode)
            2'd0:    i_m_axis_tready <= 1'b1;
            2'd1:    i_m_axis_tready <= 1'($urandom_range(0, 1));
            2'd2:    i_m_axis_tready <= (rx_cnt[1:0] == 2'd0);
            default: i_m_axis_tready <= (rx_cnt[3:0] < 4'd12);
        endcase
    end

    // result checker: oldest expectation against each output transaction
    always @(posedge i_clk) begin : result_check
        avg_result_t exp_r;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_avgs.size() == 0) begin
                $display("%0t: result with nothing expected, tdata=%h tuser=%b",
                         $time, o_m_axis_tdata, o_m_axis_tuser);
                err_count++;
            end else begin
                exp_r = pending_avgs.pop_front();
                for (int a = 0; a < AXES; a++) begin
                    if (exp_r.avgs[a*SAMPLE_W +: SAMPLE_W] !==
                        o_m_axis_tdata[a*SAMPLE_W +: SAMPLE_W]) begin
                        $display("%0t: axis %0d average expected %0d, got %0d", $time, a,
                                 $signed(exp_r.avgs[a*SAMPLE_W +: SAMPLE_W]),
                                 $signed(o_m_axis_tdata[a*SAMPLE_W +: SAMPLE_W]));
                        err_count++;
                    end
                end
                if (exp_r.bias_valid !== o_m_axis_tuser) begin
                    $display("%0t: bias_valid expected %b, got %b",
                             $time, exp_r.bias_valid, o_m_axis_tuser);
                    err_count++;
                end
            end
        end
    end

    // watchdog: any handshake on either side restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus: directed table first, then random traffic made mostly of
    // whole calibration runs and filter bursts, with some noise in between.
    // -----------------------------------------------------------------------
    initial begin : stimulus
        int        pick;
        int        n;
        int        mode;
        t_sample   base;
        stim_row_t dir_table [DIR_ROWS];

        // first three rows: a single full-scale sample, then the sum going
        // to -1 (truncates to 0), then past -32768 (truncates to -3276)
        dir_table = '{
            '{ACT_FILTER,     all6(S_MAX),  1'b1, '{1'b0, all6(3276)}},
            '{ACT_FILTER,     all6(S_MIN),  1'b1, '{1'b0, all6(0)}},
            '{ACT_FILTER,     all6(S_MIN),  1'b1, '{1'b0, all6(-3276)}},
            '{ACT_FILTER,     pack6(1, -1, 12345, -12345, 0, S_MAX), 1'b0, '0},
            '{ACT_RESERVED,   all6(S_MAX),  1'b0, '0},
            '{ACT_FILTER,     pack6(-9, 9, 100, -100, S_MIN, 7),     1'b0, '0},
            // calibration samples straight out of reset, no begin first
            '{ACT_CAL_SAMPLE, pack6(0, 0, 0, S_MAX, S_MAX, S_MAX),   1'b0, '0},
            '{ACT_CAL_SAMPLE, pack6(0, 0, 0, S_MIN, S_MIN, S_MIN),   1'b0, '0},
            // filtering continues while a calibration is counting
            '{ACT_FILTER,     pack6(3, -3, 5, -5, S_MAX, S_MIN),     1'b0, '0},
            '{ACT_CAL_BEGIN,  all6(16'sh5A5A), 1'b0, '0},
            '{ACT_CAL_SAMPLE, all6(-77),    1'b0, '0},
            '{ACT_FILTER,     pack6(S_MAX, S_MIN, 0, -1, 1, -2),     1'b0, '0},
            '{ACT_RESERVED,   all6(S_MIN),  1'b0, '0},
            '{ACT_FILTER,     all6(0),      1'b0, '0}
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_table[r]) begin
            send_item(dir_table[r].act, dir_table[r].data,
                      dir_table[r].row_fixed, dir_table[r].want);
        end

        items_done = 0;
        while (items_done < RAND_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                repeat ($urandom_range(1, 30)) send_item(ACT_FILTER, rand_frame(), 1'b0, '0);
            end else if (pick < 80) begin
                // calibration run: usually begun, usually complete, sometimes
                // overrun by a few samples that must be ignored
                if ($urandom_range(0, 9) != 0) begin
                    send_item(ACT_CAL_BEGIN, rand_frame(), 1'b0, '0);
                end
                n    = ($urandom_range(0, 5) == 0) ? $urandom_range(1, CAL_TOTAL - 1)
                                                   : CAL_TOTAL + $urandom_range(0, 3);
                mode = $urandom_range(0, 3);
                base = rand_sample();
                repeat (n) begin
                    if ($urandom_range(0, 4) == 0) begin
                        send_item(ACT_FILTER, rand_frame(), 1'b0, '0);
                    end
                    send_item(ACT_CAL_SAMPLE,
                              pack6(rand_sample(), rand_sample(), rand_sample(),
                                    gyro_pick(mode, base), gyro_pick(mode, base),
                                    gyro_pick(mode, base)),
                              1'b0, '0);
                end
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 3)) begin
                    if ($urandom_range(0, 1) == 0) begin
                        send_item(ACT_RESERVED, rand_frame(), 1'b0, '0);
                    end else begin
                        send_item(ACT_CAL_SAMPLE, rand_frame(), 1'b0, '0);
                    end
                end
            end else begin
                // a begin alone drops bias_valid and the offsets
                send_item(ACT_CAL_BEGIN, rand_frame(), 1'b0, '0);
                repeat ($urandom_range(1, 12)) send_item(ACT_FILTER, rand_frame(), 1'b0, '0);
            end
        end
        i_s_axis_tvalid <= 1'b0;

        while (pending_avgs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/imu_ma_pkg.sv
sv/imu_ma_window.sv
sv/imu_ma_cal.sv
sv/imu_ma_out.sv
sv/imu_six_axis_moving_average.sv
test/tb_top.sv
